[rtl/cover_crop_nearest_scaler_assert.svh]
// Assertion macros shared by the cover-crop scaler RTL.
`ifndef COVER_CROP_NEAREST_SCALER_ASSERT_SVH
`define COVER_CROP_NEAREST_SCALER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCNS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cover crop scaler: assertion failed");

// Next-cycle implication.
`define CCNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cover crop scaler: assertion failed");

// Implication after a fixed number of cycles.
`define CCNS_ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##n (cons)) \
		else $error("cover crop scaler: assertion failed");

`endif

[rtl/ccns_pkg.sv]
// Types and fixed constants of the cover-crop nearest-neighbour scaler.
package ccns_pkg;

	// Port widths fixed by the interface
	localparam int COORD_W   = 12;
	localparam int CFG_W     = 13;
	localparam int BIAS_W    = 9;
	localparam int OFFS_W    = 26;
	localparam int CFG_IDX_W = 3;

	// Q1.8 bias: one is 256, reset value is the centre
	localparam int BIAS_FRAC = 8;
	localparam logic [BIAS_W-1:0] BIAS_ONE   = 9'd256;
	localparam logic [BIAS_W-1:0] BIAS_RESET = 9'd128;

	// RGBA: four bytes per pixel
	localparam int BYTE_SHIFT = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DST_WIDTH  = 3'd0,
		REG_DST_HEIGHT = 3'd1,
		REG_SRC_WIDTH  = 3'd2,
		REG_SRC_HEIGHT = 3'd3,
		REG_VBIAS      = 3'd4
	} cfg_reg_t;

	// Crop window setup sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_OFF
	} setup_state_t;

endpackage

[rtl/cover_crop_nearest_scaler.sv]
// Cover-crop nearest-neighbour scaler: destination pixel to source pixel address.
//
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write the destination and
// source sizes and the Q1.8 vertical bias, one register per write. Every
// write starts the crop window setup, which holds busy high while one
// serial divider works out the window size and offset. Reset leaves all
// sizes at one, bias at the centre, and busy low at once.
// Pixel channel: a beat (dst_x, dst_y) is taken on a clock edge with start
// high and busy low; while busy stays low a new beat may follow in every
// cycle. The result beat (src_x, src_y, src_byte_offset, out_of_range)
// appears with done high for one cycle, in order. The per-pixel restoring
// dividers give one quotient bit per pipeline stage, for x and y side by side.
// The receiver cannot stall: results are presented once and not held.
// Reset empties the pipeline; beats in flight are dropped.

`include "cover_crop_nearest_scaler_assert.svh"

module cover_crop_nearest_scaler #(
	parameter int MAX_DIM = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [ccns_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ccns_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                            start,
	output logic                            busy,
	input  logic [ccns_pkg::COORD_W-1:0]    dst_x,
	input  logic [ccns_pkg::COORD_W-1:0]    dst_y,
	output logic                            done,
	output logic [ccns_pkg::COORD_W-1:0]    src_x,
	output logic [ccns_pkg::COORD_W-1:0]    src_y,
	output logic [ccns_pkg::OFFS_W-1:0]     src_byte_offset,
	output logic                            out_of_range
);
	import ccns_pkg::*;

	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int QW    = $clog2(MAX_DIM);
	localparam int CW    = (DW > CFG_W) ? DW : CFG_W;
	localparam int XW    = (DW > COORD_W) ? DW : COORD_W;
	localparam int NW    = COORD_W + DW;
	localparam int LW    = DW + QW;
	localparam int SW    = 2 * DW;
	localparam int PW    = SW + BYTE_SHIFT;
	localparam int MW    = DW + BIAS_W;
	localparam int CNT_W = $clog2(DW);
	localparam int LAT   = QW + 4;

	// Saturate a size register to 1..MAX_DIM
	function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [CW-1:0] ve;
		ve = CW'(v);
		if (ve == '0)
			return DW'(1);
		if (ve > CW'(MAX_DIM))
			return DW'(MAX_DIM);
		return DW'(ve);
	endfunction

	// One restoring division step on {remainder, numerator low bits}, per-pixel lane
	function automatic logic [LW-1:0] lane_step(input logic [LW-1:0] w,
		input logic [DW-1:0] d);
		logic [DW:0] top;
		logic [DW:0] diff;
		logic        qb;
		top  = w[LW-1:QW-1];
		diff = top - {1'b0, d};
		qb   = (top >= {1'b0, d});
		return {(qb ? diff[DW-1:0] : top[DW-1:0]), w[QW-2:0], qb};
	endfunction

	// Same step for the setup divider, DW quotient bits
	function automatic logic [SW-1:0] seq_step(input logic [SW-1:0] w,
		input logic [DW-1:0] d);
		logic [DW:0] top;
		logic [DW:0] diff;
		logic        qb;
		top  = w[SW-1:DW-1];
		diff = top - {1'b0, d};
		qb   = (top >= {1'b0, d});
		return {(qb ? diff[DW-1:0] : top[DW-1:0]), w[DW-2:0], qb};
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	logic [CFG_W-1:0]  dst_w_q, dst_h_q, src_w_q, src_h_q;
	logic [BIAS_W-1:0] bias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_w_q <= CFG_W'(1);
			dst_h_q <= CFG_W'(1);
			src_w_q <= CFG_W'(1);
			src_h_q <= CFG_W'(1);
			bias_q  <= BIAS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DST_WIDTH:  dst_w_q <= cfg_wdata;
				REG_DST_HEIGHT: dst_h_q <= cfg_wdata;
				REG_SRC_WIDTH:  src_w_q <= cfg_wdata;
				REG_SRC_HEIGHT: src_h_q <= cfg_wdata;
				REG_VBIAS:      bias_q  <= cfg_wdata[BIAS_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamped sizes and bias
	logic [DW-1:0]     dw_c, dh_c, sw_c, sh_c;
	logic [BIAS_W-1:0] bias_c;

	assign dw_c   = clamp_dim(dst_w_q);
	assign dh_c   = clamp_dim(dst_h_q);
	assign sw_c   = clamp_dim(src_w_q);
	assign sh_c   = clamp_dim(src_h_q);
	assign bias_c = (bias_q > BIAS_ONE) ? BIAS_ONE : bias_q;

	// ------------------------------------------------------------------
	// Crop window setup sequencer
	setup_state_t    state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]    p1_q, p2_q, sdv_q;
	logic [DW-1:0]    sdiv_q;
	logic             wide_q;
	logic [DW-1:0]    win_w_q, win_h_q, off_x_q, off_y_q;
	logic [DW-1:0]    win_raw, win_cl;
	logic [MW-1:0]    off_y_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: state_d = ST_IDLE;
			ST_MUL:  state_d = ST_LOAD;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(DW - 1))
					state_d = ST_OFF;
			end
			ST_OFF:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		// any write restarts the setup
		if (cfg_wr_en)
			state_d = ST_MUL;
	end

	assign busy = (state_q != ST_IDLE);

	// Window size from the divider, clamped to at least one
	assign win_raw    = sdv_q[DW-1:0];
	assign win_cl     = (win_raw == '0) ? DW'(1) : win_raw;
	assign off_y_prod = MW'(sh_c - win_raw) * MW'(bias_c);

	// Cross products, division and offsets
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_MUL: begin
				p1_q <= SW'(sw_c) * SW'(dh_c);
				p2_q <= SW'(dw_c) * SW'(sh_c);
			end
			ST_LOAD: begin
				wide_q <= (p1_q > p2_q);
				sdv_q  <= (p1_q > p2_q) ? p2_q : p1_q;
				sdiv_q <= (p1_q > p2_q) ? dh_c : dw_c;
			end
			ST_DIV:  sdv_q <= seq_step(sdv_q, sdiv_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			win_w_q <= DW'(1);
			win_h_q <= DW'(1);
			off_x_q <= '0;
			off_y_q <= '0;
		end else begin
			if (state_q == ST_LOAD)
				cnt_q <= '0;
			else if (state_q == ST_DIV)
				cnt_q <= cnt_q + CNT_W'(1);
			if (state_q == ST_OFF) begin
				if (wide_q) begin
					// source wider: centred column crop
					win_w_q <= win_cl;
					win_h_q <= sh_c;
					off_x_q <= (sw_c - win_raw) >> 1;
					off_y_q <= '0;
				end else begin
					// source taller: biased row crop
					win_w_q <= sw_c;
					win_h_q <= win_cl;
					off_x_q <= '0;
					off_y_q <= DW'(off_y_prod >> BIAS_FRAC);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Pixel pipeline
	logic          accept;
	logic [NW-1:0] nx, ny;
	logic          oor_in;

	assign accept = start && !busy;
	assign nx     = NW'(dst_x) * NW'(win_w_q);
	assign ny     = NW'(dst_y) * NW'(win_h_q);
	assign oor_in = (XW'(dst_x) >= XW'(dw_c)) || (XW'(dst_y) >= XW'(dh_c));

	// Divider lanes: element 0 is stage one, element QW holds the quotients
	logic          dv_v_s   [QW+1];
	logic          dv_oor_s [QW+1];
	logic [LW-1:0] dv_x_s   [QW+1];
	logic [LW-1:0] dv_y_s   [QW+1];

	logic                v_s2, v_s3, v_s4;
	logic                oor_s2, oor_s3;
	logic [DW-1:0]       sx_s2, sy_s2, sx_s3, sy_s3;
	logic [SW-1:0]       prod_s3;
	logic [COORD_W-1:0]  src_x_s4, src_y_s4;
	logic [OFFS_W-1:0]   offs_s4;
	logic                oor_s4;

	// Offset add and saturation to the last column / row
	logic [QW-1:0] qx, qy;
	logic [DW:0]   sumx, sumy;
	logic [DW-1:0] sw_m1, sh_m1, sx_sat, sy_sat;

	assign qx     = dv_x_s[QW][QW-1:0];
	assign qy     = dv_y_s[QW][QW-1:0];
	assign sumx   = (DW+1)'(off_x_q) + (DW+1)'(qx);
	assign sumy   = (DW+1)'(off_y_q) + (DW+1)'(qy);
	assign sw_m1  = sw_c - DW'(1);
	assign sh_m1  = sh_c - DW'(1);
	assign sx_sat = (sumx > (DW+1)'(sw_m1)) ? sw_m1 : DW'(sumx);
	assign sy_sat = (sumy > (DW+1)'(sh_m1)) ? sh_m1 : DW'(sumy);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QW; k++)
				dv_v_s[k] <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			dv_v_s[0] <= accept;
			for (int k = 1; k <= QW; k++)
				dv_v_s[k] <= dv_v_s[k-1];
			v_s2 <= dv_v_s[QW];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		// stage one: products and range check
		dv_oor_s[0] <= oor_in;
		dv_x_s[0]   <= {DW'(nx >> QW), QW'(nx)};
		dv_y_s[0]   <= {DW'(ny >> QW), QW'(ny)};
		// one quotient bit per stage
		for (int k = 1; k <= QW; k++) begin
			dv_oor_s[k] <= dv_oor_s[k-1];
			dv_x_s[k]   <= lane_step(dv_x_s[k-1], dw_c);
			dv_y_s[k]   <= lane_step(dv_y_s[k-1], dh_c);
		end
		// add crop offsets, saturate
		oor_s2 <= dv_oor_s[QW];
		sx_s2  <= sx_sat;
		sy_s2  <= sy_sat;
		// row times source width
		oor_s3  <= oor_s2;
		sx_s3   <= sx_s2;
		sy_s3   <= sy_s2;
		prod_s3 <= SW'(sy_s2) * SW'(sw_c);
		// output beat, zeroed when out of range
		oor_s4   <= oor_s3;
		src_x_s4 <= oor_s3 ? '0 : COORD_W'(sx_s3);
		src_y_s4 <= oor_s3 ? '0 : COORD_W'(sy_s3);
		offs_s4  <= oor_s3 ? '0
			: OFFS_W'((PW'(prod_s3) + PW'(sx_s3)) << BYTE_SHIFT);
	end

	assign done            = v_s4;
	assign src_x           = src_x_s4;
	assign src_y           = src_y_s4;
	assign src_byte_offset = offs_s4;
	assign out_of_range    = oor_s4;

	// ------------------------------------------------------------------
	// Assertions
	`CCNS_ASSERT_DELAY(a_fixed_latency, clk, arst_n, accept, LAT, done)
	`CCNS_ASSERT_IMPL(a_oor_zero, clk, arst_n, done && out_of_range, src_x == '0 && src_y == '0 && src_byte_offset == '0)
	`CCNS_ASSERT_NEXT(a_cfg_starts_setup, clk, arst_n, cfg_wr_en, busy)
	`CCNS_ASSERT_IMPL(a_window_nonzero, clk, arst_n, 1'b1, win_w_q != '0 && win_h_q != '0)

endmodule
